FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define ASSERT_ACTIVE(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed while active");

// Property checked at every edge, reset included.
`define ASSERT_EVERY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/ppsz_pkg.sv
`default_nettype none
package ppsz_pkg;

    localparam int NUM_W = 36;            // divider numerator width
    localparam int DEN_W = 24;            // divider denominator width
    localparam int ADDR_MAX_W = 24;       // depth address, largest frame
    localparam logic [19:0] DEPTH_NUMER = 20'h80000;

    typedef enum logic {
        OP_DRAW,
        OP_DEPTH
    } t_op;

    typedef enum logic [2:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_WINDOW_LEFT,
        REG_WINDOW_TOP,
        REG_WINDOW_RIGHT,
        REG_WINDOW_BOTTOM,
        REG_SIZE_SHIFT,
        REG_ASPECT_SHIFT
    } t_reg_idx;

    typedef struct packed {
        logic [12:0] center_x;
        logic [11:0] center_y;
        logic [8:0]  window_left;
        logic [7:0]  window_top;
        logic [8:0]  window_right;
        logic [7:0]  window_bottom;
        logic [3:0]  size_shift;
        logic        aspect_shift;
    } t_cfg;

    typedef struct packed {
        t_op                   op;
        logic [ADDR_MAX_W-1:0] addr;
        logic [8:0]            u;
        logic [7:0]            v;
        logic [2:0]            cols;
        logic [3:0]            rows;
        logic [15:0]           depth;
        logic [7:0]            color;
    } t_cmd;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MULU,
        F_PREU,
        F_DIVU,
        F_MULV,
        F_PREV,
        F_DIVV,
        F_WIN,
        F_PRED,
        F_DIVD,
        F_SIZE,
        F_ADDR,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_TEST
    } t_back_state;

endpackage
`default_nettype wire

FILE: hw/rtl/particle_point_sprite_zbuffer.sv
// Depth-tested point sprite rasterizer for particles.
// Input stream: one beat per particle (tuser=0) or per depth write (tuser=1).
// Draw beats are culled when too near, projected to (u,v) by two divides,
// given a 1/z depth by a third, and sized; a square of up to 4x8 pixels is
// then walked and each on-frame pixel is depth tested and sent as one beat
// on the output stream, tlast on the final pixel. Culled items send nothing.
// Front: three serial divides through one shared divider per draw beat, none
// per depth-write beat. Back: each pixel's depth is read, then tested, and
// written when the test passes. A two-entry command queue lets the front
// project the next particle while the back walks.
// Reset: config returns to defaults, then the depth buffer is cleared one
// entry a cycle (FRAME_WIDTH*FRAME_HEIGHT entries, 76800 at default); input
// tready stays low during that pass, APB writes are taken throughout.
// A stalled output holds its beat in the output register; the back waits,
// the queue fills, and the front then stops taking input beats.
// Config via APB: register i at byte address 4*i, pready always high.
`default_nettype none
module particle_point_sprite_zbuffer #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240,
    parameter int SIZE_MIN     = 1,
    parameter int SIZE_MAX     = 4,
    parameter int Z_CLIP       = 128
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // view_x[20:0] view_y[41:21] view_z[62:42] color[70:63]
    // at_x[79:71] at_y[87:80] depth_in[102:88], zero pad [103]
    input  wire logic [103:0] s_axis_tdata,
    // kind
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pixel_x[8:0] pixel_y[16:9] pixel_color[24:17], zero pad [31:25]
    output logic [31:0]       m_axis_tdata,
    // write
    output logic              m_axis_tuser,
    output logic              m_axis_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    ppsz_pkg::t_cfg   r_cfg;
    ppsz_pkg::t_reg_idx reg_idx;
    ppsz_pkg::t_cmd   push_cmd, q_cmd;
    logic             push, q_full, q_valid, q_pop, clearing;
    logic [8:0]       out_x;
    logic [7:0]       out_y, out_color;

    assign pready  = 1'b1;
    assign reg_idx = ppsz_pkg::t_reg_idx'(paddr[4:2]);

    // register file, written on the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x      <= 13'd2552;
            r_cfg.center_y      <= 12'd1912;
            r_cfg.window_left   <= 9'd0;
            r_cfg.window_top    <= 8'd0;
            r_cfg.window_right  <= 9'd316;
            r_cfg.window_bottom <= 8'd236;
            r_cfg.size_shift    <= 4'd7;
            r_cfg.aspect_shift  <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                ppsz_pkg::REG_CENTER_X:      r_cfg.center_x      <= pwdata[12:0];
                ppsz_pkg::REG_CENTER_Y:      r_cfg.center_y      <= pwdata[11:0];
                ppsz_pkg::REG_WINDOW_LEFT:   r_cfg.window_left   <= pwdata[8:0];
                ppsz_pkg::REG_WINDOW_TOP:    r_cfg.window_top    <= pwdata[7:0];
                ppsz_pkg::REG_WINDOW_RIGHT:  r_cfg.window_right  <= pwdata[8:0];
                ppsz_pkg::REG_WINDOW_BOTTOM: r_cfg.window_bottom <= pwdata[7:0];
                ppsz_pkg::REG_SIZE_SHIFT:    r_cfg.size_shift    <= pwdata[3:0];
                ppsz_pkg::REG_ASPECT_SHIFT:  r_cfg.aspect_shift  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ppsz_pkg::REG_CENTER_X:      prdata = 32'(r_cfg.center_x);
            ppsz_pkg::REG_CENTER_Y:      prdata = 32'(r_cfg.center_y);
            ppsz_pkg::REG_WINDOW_LEFT:   prdata = 32'(r_cfg.window_left);
            ppsz_pkg::REG_WINDOW_TOP:    prdata = 32'(r_cfg.window_top);
            ppsz_pkg::REG_WINDOW_RIGHT:  prdata = 32'(r_cfg.window_right);
            ppsz_pkg::REG_WINDOW_BOTTOM: prdata = 32'(r_cfg.window_bottom);
            ppsz_pkg::REG_SIZE_SHIFT:    prdata = 32'(r_cfg.size_shift);
            ppsz_pkg::REG_ASPECT_SHIFT:  prdata = 32'(r_cfg.aspect_shift);
            default:                     prdata = '0;
        endcase
    end

    ppsz_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .SIZE_MIN     (SIZE_MIN),
        .SIZE_MAX     (SIZE_MAX),
        .Z_CLIP       (Z_CLIP)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_clearing (clearing),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_kind     (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (q_full)
    );

    ppsz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    ppsz_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (clearing),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_x        (out_x),
        .o_y        (out_y),
        .o_color    (out_color),
        .o_write    (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, out_color, out_y, out_x};
endmodule
`default_nettype wire

FILE: hw/rtl/ppsz_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ppsz_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ppsz_pkg::NUM_W-1:0]  i_num,
    input  wire logic [ppsz_pkg::DEN_W-1:0]  i_den,
    output logic                             o_done,
    output logic [ppsz_pkg::NUM_W-1:0]       o_quo
);
    localparam int NW = ppsz_pkg::NUM_W;
    localparam int DW = ppsz_pkg::DEN_W;
    localparam int CW = $clog2(NW);
    localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic          ge;

    assign trial = {r_rem, r_quo[NW-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= {r_quo[NW-2:0], ge};
                r_rem <= ge ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

FILE: hw/rtl/ppsz_front.sv
`default_nettype none
// Accepts beats, culls, projects and sizes particles, emits commands.
module ppsz_front #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240,
    parameter int SIZE_MIN     = 1,
    parameter int SIZE_MAX     = 4,
    parameter int Z_CLIP       = 128
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ppsz_pkg::t_cfg  i_cfg,
    input  wire logic            i_clearing,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic            i_kind,
    input  wire logic [103:0]    i_data,
    output logic                 o_push,
    output ppsz_pkg::t_cmd       o_cmd,
    input  wire logic            i_full
);
    localparam int NW = ppsz_pkg::NUM_W;
    localparam int DW = ppsz_pkg::DEN_W;

    ppsz_pkg::t_front_state r_state, n_state;

    logic signed [20:0] r_x, r_y, r_z;
    logic [7:0]         r_color;
    logic [8:0]         r_atx;
    logic [7:0]         r_aty;
    logic [14:0]        r_din;
    logic               r_kind;
    logic signed [NW-1:0] r_num;
    logic signed [NW:0]   r_u, r_v;
    logic [15:0]        r_depth;
    logic [2:0]         r_cols;
    logic [3:0]         r_rows;
    ppsz_pkg::t_cmd     r_cmd;

    logic               accept;
    logic signed [20:0] in_z;
    logic [32:0]        mul;
    logic signed [NW-1:0] num_calc;
    logic               neg;
    logic [NW-1:0]      mag;
    logic [DW-1:0]      den16;
    logic               div_start;
    logic [NW-1:0]      div_num;
    logic [DW-1:0]      div_den;
    logic               div_done;
    logic [NW-1:0]      div_quo;
    logic signed [NW:0] quo_s;
    logic               win_miss;
    logic [15:0]        shifted;
    logic [2:0]         size;
    logic [3:0]         rows;
    logic [2:0]         cols_eff;
    logic [3:0]         rows_eff;
    logic [8:0]         u9;
    logic [7:0]         v8;

    assign in_z   = $signed(i_data[62:42]);
    assign accept = i_valid && o_ready;
    assign u9     = r_u[8:0];
    assign v8     = r_v[7:0];

    // shared multiplier: center times z for either axis
    assign mul = 33'(r_z[19:0]) *
                 33'((r_state == ppsz_pkg::F_MULU) ? i_cfg.center_x : {1'b0, i_cfg.center_y});
    assign num_calc = $signed(NW'(mul))
                    + ((r_state == ppsz_pkg::F_MULU) ? ($signed(NW'(r_x)) <<< 4)
                                                     : -($signed(NW'(r_y)) <<< 4))
                    + ($signed(NW'(r_z)) <<< 3);

    // floor of a negative quotient: divide |n|+d-1 and negate
    assign neg   = r_num[NW-1];
    assign mag   = neg ? NW'(-r_num) : NW'(r_num);
    assign den16 = {r_z[19:0], 4'b0};

    always_comb begin
        div_start = 1'b0;
        div_num   = neg ? NW'(mag + NW'(den16) - NW'(1)) : mag;
        div_den   = den16;
        case (r_state)
            ppsz_pkg::F_PREU, ppsz_pkg::F_PREV: div_start = 1'b1;
            ppsz_pkg::F_PRED: begin
                div_start = 1'b1;
                div_num   = NW'(ppsz_pkg::DEPTH_NUMER);
                div_den   = DW'(r_z[19:0]);
            end
            default: ;
        endcase
    end

    assign quo_s = neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    ppsz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign win_miss = (r_v > $signed((NW+1)'(i_cfg.window_bottom)))
                   || (r_u > $signed((NW+1)'(i_cfg.window_right)))
                   || (r_v < $signed((NW+1)'(i_cfg.window_top)))
                   || (r_u < $signed((NW+1)'(i_cfg.window_left)));

    // square size and the part of it that lies on the frame
    always_comb begin
        shifted = r_depth >> i_cfg.size_shift;
        if (int'(shifted) < SIZE_MIN)      size = 3'(SIZE_MIN);
        else if (int'(shifted) > SIZE_MAX) size = 3'(SIZE_MAX);
        else                               size = shifted[2:0];
        rows = {1'b0, size} << i_cfg.aspect_shift;
        if (int'(u9) + int'(size) <= FRAME_WIDTH) cols_eff = size;
        else if (int'(u9) < FRAME_WIDTH)          cols_eff = 3'(FRAME_WIDTH - int'(u9));
        else                                      cols_eff = '0;
        if (int'(v8) + int'(rows) <= FRAME_HEIGHT) rows_eff = rows;
        else if (int'(v8) < FRAME_HEIGHT)          rows_eff = 4'(FRAME_HEIGHT - int'(v8));
        else                                       rows_eff = '0;
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        case (r_state)
            ppsz_pkg::F_IDLE: begin
                o_ready = !i_clearing;
                if (accept) begin
                    if (i_kind) begin
                        if (int'(i_data[79:71]) < FRAME_WIDTH
                                && int'(i_data[87:80]) < FRAME_HEIGHT)
                            n_state = ppsz_pkg::F_ADDR;
                    end else if (in_z >= Z_CLIP) begin
                        n_state = ppsz_pkg::F_MULU;
                    end
                end
            end
            ppsz_pkg::F_MULU: n_state = ppsz_pkg::F_PREU;
            ppsz_pkg::F_PREU: n_state = ppsz_pkg::F_DIVU;
            ppsz_pkg::F_DIVU: if (div_done) n_state = ppsz_pkg::F_MULV;
            ppsz_pkg::F_MULV: n_state = ppsz_pkg::F_PREV;
            ppsz_pkg::F_PREV: n_state = ppsz_pkg::F_DIVV;
            ppsz_pkg::F_DIVV: if (div_done) n_state = ppsz_pkg::F_WIN;
            ppsz_pkg::F_WIN:  n_state = win_miss ? ppsz_pkg::F_IDLE : ppsz_pkg::F_PRED;
            ppsz_pkg::F_PRED: n_state = ppsz_pkg::F_DIVD;
            ppsz_pkg::F_DIVD: if (div_done) n_state = ppsz_pkg::F_SIZE;
            ppsz_pkg::F_SIZE:
                n_state = (cols_eff == '0 || rows_eff == '0) ? ppsz_pkg::F_IDLE
                                                             : ppsz_pkg::F_ADDR;
            ppsz_pkg::F_ADDR: n_state = ppsz_pkg::F_PUSH;
            ppsz_pkg::F_PUSH: if (!i_full) n_state = ppsz_pkg::F_IDLE;
            default: n_state = ppsz_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ppsz_pkg::F_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_x     <= $signed(i_data[20:0]);
            r_y     <= $signed(i_data[41:21]);
            r_z     <= in_z;
            r_color <= i_data[70:63];
            r_atx   <= i_data[79:71];
            r_aty   <= i_data[87:80];
            r_din   <= i_data[102:88];
        end
        if (r_state == ppsz_pkg::F_MULU || r_state == ppsz_pkg::F_MULV)
            r_num <= num_calc;
        if (r_state == ppsz_pkg::F_DIVU && div_done) r_u <= quo_s;
        if (r_state == ppsz_pkg::F_DIVV && div_done) r_v <= quo_s;
        if (r_state == ppsz_pkg::F_DIVD && div_done) r_depth <= div_quo[15:0];
        if (r_state == ppsz_pkg::F_SIZE) begin
            r_cols <= cols_eff;
            r_rows <= rows_eff;
        end
        if (r_state == ppsz_pkg::F_ADDR) begin
            r_cmd.color <= r_color;
            r_cmd.cols  <= r_cols;
            r_cmd.rows  <= r_rows;
            if (r_kind) begin
                r_cmd.op    <= ppsz_pkg::OP_DEPTH;
                r_cmd.addr  <= ppsz_pkg::ADDR_MAX_W'(int'(r_aty) * FRAME_WIDTH + int'(r_atx));
                r_cmd.depth <= {1'b0, r_din};
                r_cmd.u     <= r_atx;
                r_cmd.v     <= r_aty;
            end else begin
                r_cmd.op    <= ppsz_pkg::OP_DRAW;
                r_cmd.addr  <= ppsz_pkg::ADDR_MAX_W'(int'(v8) * FRAME_WIDTH + int'(u9));
                r_cmd.depth <= r_depth;
                r_cmd.u     <= u9;
                r_cmd.v     <= v8;
            end
        end
    end

    assign o_push = (r_state == ppsz_pkg::F_PUSH) && !i_full;
    assign o_cmd  = r_cmd;
endmodule
`default_nettype wire

FILE: hw/rtl/ppsz_queue.sv
`default_nettype none
// Two-entry command queue between front and back.
module ppsz_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ppsz_pkg::t_cmd  i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output ppsz_pkg::t_cmd       o_cmd
);
    ppsz_pkg::t_cmd r_slot [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_cmd;
    end

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_slot[r_rp];
endmodule
`default_nettype wire

FILE: hw/rtl/ppsz_back.sv
`default_nettype none
// Depth buffer, square walk with read-modify-write, result register.
module ppsz_back #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    output logic                 o_clearing,
    input  wire logic            i_q_valid,
    input  wire ppsz_pkg::t_cmd  i_q_cmd,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [8:0]           o_x,
    output logic [7:0]           o_y,
    output logic [7:0]           o_color,
    output logic                 o_write,
    output logic                 o_last
);
    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
    localparam logic [AW-1:0] STRIDE    = AW'(FRAME_WIDTH);

    ppsz_pkg::t_back_state r_state, n_state;

    logic [15:0]    r_mem [DEPTH];
    logic [15:0]    r_rd;
    logic [AW-1:0]  r_clr;
    ppsz_pkg::t_cmd r_cmd;
    logic [AW-1:0]  r_addr, r_row_base;
    logic [2:0]     r_col;
    logic [3:0]     r_row;
    logic           r_ovalid;
    logic [8:0]     r_ox;
    logic [7:0]     r_oy;
    logic [7:0]     r_ocolor;
    logic           r_owrite;
    logic           r_olast;

    logic           we, re, emit, pass, col_end, is_last;
    logic [AW-1:0]  waddr;
    logic [15:0]    wdata;

    assign pass    = r_rd <= r_cmd.depth;
    assign col_end = r_col == r_cmd.cols - 3'd1;
    assign is_last = col_end && (r_row == r_cmd.rows - 4'd1);

    always_comb begin
        n_state = r_state;
        we      = 1'b0;
        re      = 1'b0;
        emit    = 1'b0;
        o_q_pop = 1'b0;
        waddr   = r_addr;
        wdata   = r_cmd.depth;
        case (r_state)
            ppsz_pkg::B_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                if (r_clr == ADDR_LAST) n_state = ppsz_pkg::B_IDLE;
            end
            ppsz_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.op == ppsz_pkg::OP_DEPTH) begin
                        we    = 1'b1;
                        waddr = i_q_cmd.addr[AW-1:0];
                        wdata = i_q_cmd.depth;
                    end else begin
                        n_state = ppsz_pkg::B_READ;
                    end
                end
            end
            ppsz_pkg::B_READ: begin
                re      = 1'b1;
                n_state = ppsz_pkg::B_TEST;
            end
            ppsz_pkg::B_TEST: begin
                if (!r_ovalid || i_ready) begin
                    emit    = 1'b1;
                    we      = pass;
                    n_state = is_last ? ppsz_pkg::B_IDLE : ppsz_pkg::B_READ;
                end
            end
            default: n_state = ppsz_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (re) r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ppsz_pkg::B_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ppsz_pkg::B_CLEAR) r_clr <= r_clr + 1'b1;
            if (emit)         r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ppsz_pkg::B_IDLE && o_q_pop) begin
            r_cmd      <= i_q_cmd;
            r_addr     <= i_q_cmd.addr[AW-1:0];
            r_row_base <= i_q_cmd.addr[AW-1:0];
            r_col      <= '0;
            r_row      <= '0;
        end
        if (emit) begin
            r_ox     <= r_cmd.u + 9'(r_col);
            r_oy     <= r_cmd.v + 8'(r_row);
            r_ocolor <= r_cmd.color;
            r_owrite <= pass;
            r_olast  <= is_last;
            if (col_end) begin
                r_col      <= '0;
                r_row      <= r_row + 4'd1;
                r_row_base <= r_row_base + STRIDE;
                r_addr     <= r_row_base + STRIDE;
            end else begin
                r_col  <= r_col + 3'd1;
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    assign o_clearing = r_state == ppsz_pkg::B_CLEAR;
    assign o_valid    = r_ovalid;
    assign o_x        = r_ox;
    assign o_y        = r_oy;
    assign o_color    = r_ocolor;
    assign o_write    = r_owrite;
    assign o_last     = r_olast;
endmodule
`default_nettype wire

FILE: hw/rtl/ppsz_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ppsz_checker #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);
    // a stalled beat holds
    `ASSERT_ACTIVE(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    // depth buffer clear keeps the input closed right after reset
    `ASSERT_EVERY(a_clear_closed, i_clk, !i_rst_n |=> !s_axis_tready)
    // only on-frame pixels leave the block
    `ASSERT_ACTIVE(a_x_on_frame, i_clk, i_rst_n, m_axis_tvalid |-> (32'(m_axis_tdata[8:0]) < FRAME_WIDTH))
    `ASSERT_ACTIVE(a_y_on_frame, i_clk, i_rst_n, m_axis_tvalid |-> (32'(m_axis_tdata[16:9]) < FRAME_HEIGHT))
endmodule

bind particle_point_sprite_zbuffer ppsz_checker #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
) u_ppsz_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
